### hdl/tpd_pkg.sv
// Package for the touch packet pen event decoder: field widths, packet
// constants, event kinds and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 32;
    localparam int COORD_W    = 10;
    localparam int POS_W      = 11;
    localparam int PRESS_W    = 9;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [BYTE_W-1:0]  ID_CODE        = 8'h81;
    localparam logic [BYTE_W-1:0]  PEN_UP_MASK    = 8'h1f;
    localparam logic [BYTE_W-1:0]  RELEASE_MASK   = 8'h7f;
    localparam logic [PRESS_W-1:0] TOUCH_PRESSURE = 9'd500;
    localparam logic [PRESS_W-1:0] NO_PRESSURE    = 9'd0;
    localparam logic [COORD_W-1:0] GLIDE_MASK_RST = 10'd1022;

    typedef enum logic [KIND_W-1:0] {
        EVT_PRESS   = 2'd0,
        EVT_GLIDE   = 2'd1,
        EVT_RELEASE = 2'd2
    } evt_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLIDE_MASK = 2'd0,
        CFG_SWAP_AXES  = 2'd1
    } cfg_idx_t;

    // Packet position: zero means waiting for a sync byte.
    typedef logic [1:0] byte_pos_t;

endpackage

### hdl/tpd_rx_if.sv
// Channel interface for received bytes from the serial line.
// Depends on tpd_pkg for field widths.
`timescale 1ns / 1ps

interface tpd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [tpd_pkg::BYTE_W-1:0]  rx_byte;
    logic                        rx_error;
    logic [tpd_pkg::TICK_W-1:0]  now_ticks;

    modport source (output valid, output rx_byte, output rx_error, output now_ticks,
                    input ready);
    modport sink   (input valid, input rx_byte, input rx_error, input now_ticks,
                    output ready);
endinterface

### hdl/tpd_evt_if.sv
// Channel interface for decoded pen events.
// Depends on tpd_pkg for field widths.
`timescale 1ns / 1ps

interface tpd_evt_if;
    logic                              valid;
    logic                              ready;
    logic [tpd_pkg::KIND_W-1:0]        event_kind;
    logic signed [tpd_pkg::POS_W-1:0]  pos_x;
    logic signed [tpd_pkg::POS_W-1:0]  pos_y;
    logic [tpd_pkg::PRESS_W-1:0]       pressure;
    logic [tpd_pkg::TICK_W-1:0]        time_ms;

    modport source (output valid, output event_kind, output pos_x, output pos_y,
                    output pressure, output time_ms, input ready);
    modport sink   (input valid, input event_kind, input pos_x, input pos_y,
                    input pressure, input time_ms, output ready);
endinterface

### hdl/touch_packet_pen_event_decoder.sv
// Top level of the touch packet pen event decoder.
// Depends on tpd_pkg, tpd_rx_if and tpd_evt_if.
`timescale 1ns / 1ps

// Usage
// The rx channel carries one received serial byte per transaction, with its
// receive error flag and the current 10 ms tick count. Bytes with the error
// flag set are dropped. A byte with bit 7 set starts a four-byte packet; a
// sync byte in the middle of a packet restarts framing at position one, and
// a data byte outside a packet is dropped.
// The evt channel carries at most one pen event per completed packet: a
// press, a glide (only when the masked position changed) or a release.
// Identification packets produce nothing.
// The event is registered in the result register after the byte that ends
// its packet has passed the input register. The block takes one byte every
// cycle as long as the result register is empty or is being emptied in the
// same cycle. When the evt receiver stalls, the event is held in the result
// register, the byte in the input register waits, and rx ready drops once
// both are full. Reset clears framing, the pen-down flag, the last position
// and both valid flags, and loads the configuration defaults (glide mask
// 1022, no axis swap). The user must write the configuration port only
// while the block is idle; the block itself does not enforce this.
module touch_packet_pen_event_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    tpd_rx_if.sink                             rx,
    tpd_evt_if.source                          evt,
    input  logic                               cfg_we,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers.
    logic [tpd_pkg::COORD_W-1:0] glide_mask_reg;
    logic                        swap_axes_reg;

    // Input register stage.
    logic                        in_valid_reg;
    logic [tpd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        in_error_reg;
    logic [tpd_pkg::TICK_W-1:0]  in_ticks_reg;

    // Framing and pen tracking state.
    tpd_pkg::byte_pos_t          pos_reg, pos_next;
    logic [tpd_pkg::BYTE_W-1:0]  b0_reg, b1_reg, b2_reg;
    logic                        pen_reg, pen_next;
    logic [tpd_pkg::COORD_W-1:0] last_x_reg, last_x_next;
    logic [tpd_pkg::COORD_W-1:0] last_y_reg, last_y_next;

    // Result register stage.
    logic                              out_valid_reg, out_valid_next;
    tpd_pkg::evt_kind_t                kind_reg, kind_next;
    logic signed [tpd_pkg::POS_W-1:0]  x_reg, x_next;
    logic signed [tpd_pkg::POS_W-1:0]  y_reg, y_next;
    logic [tpd_pkg::PRESS_W-1:0]       press_reg, press_next;
    logic [tpd_pkg::TICK_W-1:0]        time_reg, time_next;

    logic                        advance;
    logic                        work;
    logic                        is_sync;
    logic                        pkt_done;
    logic [tpd_pkg::COORD_W-1:0] field_a, field_b, px, py, mx, my;
    logic                        emit;

    // The pipeline moves whenever the result register can take a new value.
    assign advance  = !out_valid_reg || evt.ready;
    assign rx.ready = !in_valid_reg || advance;
    assign work     = in_valid_reg && advance && !in_error_reg;
    assign is_sync  = in_byte_reg[tpd_pkg::BYTE_W-1];
    // The fourth byte completes a packet while it sits in the input register.
    assign pkt_done = work && !is_sync && (pos_reg == 2'd3);

    // Position fields; the fourth byte comes straight from the input register.
    assign field_a = {b1_reg[2:0], b2_reg[6:0]};
    assign field_b = {b1_reg[6:4], in_byte_reg[6:0]};
    assign px      = swap_axes_reg ? field_b : field_a;
    assign py      = swap_axes_reg ? field_a : field_b;
    assign mx      = px & glide_mask_reg;
    assign my      = py & glide_mask_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        pen_next       = pen_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        emit           = 1'b0;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        press_next     = press_reg;
        // Ticks times ten as a sum of two shifts, wrapping at 32 bits.
        time_next      = (in_ticks_reg << 3) + (in_ticks_reg << 1);

        if (work) begin
            if (is_sync) begin
                pos_next = 2'd1;
            end else if (pos_reg != 2'd0) begin
                pos_next = pos_reg + 2'd1;
            end
        end

        if (pkt_done && (b0_reg != tpd_pkg::ID_CODE)) begin
            if (!pen_reg) begin
                if ((b0_reg & tpd_pkg::PEN_UP_MASK) == '0) begin
                    emit        = 1'b1;
                    pen_next    = 1'b1;
                    last_x_next = px;
                    last_y_next = py;
                    kind_next   = tpd_pkg::EVT_PRESS;
                    x_next      = $signed({1'b0, px});
                    y_next      = $signed({1'b0, py});
                    press_next  = tpd_pkg::TOUCH_PRESSURE;
                end
            end else if ((b0_reg & tpd_pkg::RELEASE_MASK) != '0) begin
                emit        = 1'b1;
                pen_next    = 1'b0;
                last_x_next = px;
                last_y_next = py;
                kind_next   = tpd_pkg::EVT_RELEASE;
                x_next      = '1;
                y_next      = '1;
                press_next  = tpd_pkg::NO_PRESSURE;
            end else if ((mx != last_x_reg) || (my != last_y_reg)) begin
                emit        = 1'b1;
                last_x_next = mx;
                last_y_next = my;
                kind_next   = tpd_pkg::EVT_GLIDE;
                x_next      = $signed({1'b0, mx});
                y_next      = $signed({1'b0, my});
                press_next  = tpd_pkg::TOUCH_PRESSURE;
            end
        end

        out_valid_next = advance ? emit : out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            glide_mask_reg <= tpd_pkg::GLIDE_MASK_RST;
            swap_axes_reg  <= 1'b0;
            in_valid_reg   <= 1'b0;
            pos_reg        <= 2'd0;
            pen_reg        <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    tpd_pkg::CFG_GLIDE_MASK: glide_mask_reg <= cfg_wdata;
                    tpd_pkg::CFG_SWAP_AXES:  swap_axes_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (rx.ready) begin
                in_valid_reg <= rx.valid;
            end
            pos_reg       <= pos_next;
            pen_reg       <= pen_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready) begin
            in_byte_reg  <= rx.rx_byte;
            in_error_reg <= rx.rx_error;
            in_ticks_reg <= rx.now_ticks;
        end
        if (work) begin
            if (is_sync) begin
                b0_reg <= in_byte_reg;
            end else if (pos_reg == 2'd1) begin
                b1_reg <= in_byte_reg;
            end else if (pos_reg == 2'd2) begin
                b2_reg <= in_byte_reg;
            end
        end
        if (advance && emit) begin
            kind_reg  <= kind_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            press_reg <= press_next;
            time_reg  <= time_next;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = kind_reg;
    assign evt.pos_x      = x_reg;
    assign evt.pos_y      = y_reg;
    assign evt.pressure   = press_reg;
    assign evt.time_ms    = time_reg;

endmodule

### hdl/tpd_checker.sv
// Port-level checker for the touch packet pen event decoder, with its bind.
// Depends on tpd_pkg and the decoder's top level.
`timescale 1ns / 1ps

module tpd_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rx_valid,
    input  logic                              rx_ready,
    input  logic                              rx_error,
    input  logic                              evt_valid,
    input  logic                              evt_ready,
    input  logic [tpd_pkg::KIND_W-1:0]        event_kind,
    input  logic signed [tpd_pkg::POS_W-1:0]  pos_x,
    input  logic signed [tpd_pkg::POS_W-1:0]  pos_y,
    input  logic [tpd_pkg::PRESS_W-1:0]       pressure,
    input  logic [tpd_pkg::TICK_W-1:0]        time_ms
);

    // Pen state as seen from delivered events.
    logic pen_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pen_seen_reg <= 1'b0;
        end else if (evt_valid && evt_ready) begin
            pen_seen_reg <= (event_kind != tpd_pkg::EVT_RELEASE);
        end
    end

    // A stalled event stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(time_ms) && $stable(event_kind))
    else $error("stalled event changed");

    // A new event follows an error-free byte that was accepted into the input
    // register before the result register loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) |-> $past(rx_valid && rx_ready && !rx_error, 2))
    else $error("event without a preceding byte");

    // Release carries no position and no pressure.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && event_kind == tpd_pkg::EVT_RELEASE
            |-> pos_x == -11'sd1 && pos_y == -11'sd1 && pressure == tpd_pkg::NO_PRESSURE)
    else $error("bad release fields");

    // A press only happens with the pen up, glide and release only with it down.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (event_kind == tpd_pkg::EVT_PRESS) == !pen_seen_reg)
    else $error("pen event out of order");

endmodule

bind touch_packet_pen_event_decoder tpd_checker u_tpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .rx_error   (rx.rx_error),
    .evt_valid  (evt.valid),
    .evt_ready  (evt.ready),
    .event_kind (evt.event_kind),
    .pos_x      (evt.pos_x),
    .pos_y      (evt.pos_y),
    .pressure   (evt.pressure),
    .time_ms    (evt.time_ms)
);
